// ===== sv/rsa_char_encrypt_core_assert.svh =====
// Assertion macros for the character RSA encryption core.
// Used by the port checker; no other dependencies.
`ifndef RSA_CHAR_ENCRYPT_CORE_ASSERT_SVH
`define RSA_CHAR_ENCRYPT_CORE_ASSERT_SVH

// same-cycle implication
`define RCE_ASSERT_IMP(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("rce: implication failed");

// next-cycle implication
`define RCE_ASSERT_NXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("rce: next-cycle implication failed");

`endif

// ===== sv/rce_pkg.sv =====
// Shared types and constants for the character RSA encryption core.
// No dependencies.
`default_nettype none

package rce_pkg;

    localparam int CHAR_W  = 7;
    localparam int VALUE_W = 17;
    localparam int CCHAR_W = 8;
    localparam int ADDR_W  = 3;
    localparam int DATA_W  = 32;

    localparam int RESET_P = 2;
    localparam int RESET_Q = 3;

    localparam logic [CHAR_W-1:0]  CHAR_OFFSET  = 7'd96;
    localparam logic [CCHAR_W-1:0] CCHAR_OFFSET = 8'd96;

    typedef enum logic
    {
        REG_PRIME_P,
        REG_PRIME_Q
    } reg_idx_t;

    typedef enum logic [3:0]
    {
        ST_IDLE,
        ST_KEY_MOD,
        ST_KEY_TOT,
        ST_CAND,
        ST_TDIV,
        ST_PRIME,
        ST_PDIV,
        ST_ENC_INIT,
        ST_MUL,
        ST_MDIV,
        ST_OUT
    } state_t;

endpackage

`default_nettype wire

// ===== sv/rce_cfg_regs.sv =====
// APB register file holding the two prime factors.
// Depends on rce_pkg.
`default_nettype none

module rce_cfg_regs #(
    parameter int PRIME_WIDTH = 8
) (
    input  wire logic                            clk,
    input  wire logic                            rst_n,
    input  wire logic                            psel,
    input  wire logic                            penable,
    input  wire logic                            pwrite,
    input  wire logic [rce_pkg::ADDR_W-1:0]      paddr,
    input  wire logic [rce_pkg::DATA_W-1:0]      pwdata,
    output logic      [rce_pkg::DATA_W-1:0]      prdata,
    output logic                                 pready,
    output logic      [PRIME_WIDTH-1:0]          prime_p,
    output logic      [PRIME_WIDTH-1:0]          prime_q,
    output logic                                 cfg_wr
);

    logic [PRIME_WIDTH-1:0] prime_p_reg;
    logic [PRIME_WIDTH-1:0] prime_p_next;
    logic [PRIME_WIDTH-1:0] prime_q_reg;
    logic [PRIME_WIDTH-1:0] prime_q_next;
    rce_pkg::reg_idx_t      idx;

    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite;
    assign idx    = rce_pkg::reg_idx_t'(paddr[2]);

    always_comb
    begin
        prime_p_next = prime_p_reg;
        prime_q_next = prime_q_reg;
        if (cfg_wr)
        begin
            case (idx)
                rce_pkg::REG_PRIME_P: prime_p_next = pwdata[PRIME_WIDTH-1:0];
                rce_pkg::REG_PRIME_Q: prime_q_next = pwdata[PRIME_WIDTH-1:0];
                default: ;
            endcase
        end
    end

    always_comb
    begin
        case (idx)
            rce_pkg::REG_PRIME_P: prdata = rce_pkg::DATA_W'(prime_p_reg);
            rce_pkg::REG_PRIME_Q: prdata = rce_pkg::DATA_W'(prime_q_reg);
            default:              prdata = '0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            prime_p_reg <= PRIME_WIDTH'(rce_pkg::RESET_P);
            prime_q_reg <= PRIME_WIDTH'(rce_pkg::RESET_Q);
        end
        else
        begin
            prime_p_reg <= prime_p_next;
            prime_q_reg <= prime_q_next;
        end
    end

    assign prime_p = prime_p_reg;
    assign prime_q = prime_q_reg;

endmodule

`default_nettype wire

// ===== sv/rce_rem_unit.sv =====
// Shared serial remainder unit, one dividend bit per cycle (restoring).
// Depends on rce_pkg only through its users.
`default_nettype none

module rce_rem_unit #(
    parameter int DIVIDEND_W = 24,
    parameter int DIVISOR_W  = 16
) (
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  start,
    input  wire logic [DIVIDEND_W-1:0] dividend,
    input  wire logic [DIVISOR_W-1:0]  divisor,
    output logic                       done,
    output logic      [DIVISOR_W-1:0]  remainder
);

    localparam int CNT_W = $clog2(DIVIDEND_W + 1);

    logic [DIVIDEND_W-1:0] shift_reg;
    logic [DIVIDEND_W-1:0] shift_next;
    logic [DIVISOR_W-1:0]  divisor_reg;
    logic [DIVISOR_W-1:0]  divisor_next;
    logic [DIVISOR_W-1:0]  rem_reg;
    logic [DIVISOR_W-1:0]  rem_next;
    logic [CNT_W-1:0]      count_reg;
    logic [CNT_W-1:0]      count_next;
    logic                  done_reg;
    logic                  done_next;
    logic [DIVISOR_W:0]    trial;
    logic [DIVISOR_W:0]    diff;

    assign trial = {rem_reg, shift_reg[DIVIDEND_W-1]};
    assign diff  = trial - {1'b0, divisor_reg};

    always_comb
    begin
        shift_next   = shift_reg;
        divisor_next = divisor_reg;
        rem_next     = rem_reg;
        count_next   = count_reg;
        done_next    = 1'b0;
        if (start)
        begin
            shift_next   = dividend;
            divisor_next = divisor;
            rem_next     = '0;
            count_next   = CNT_W'(DIVIDEND_W);
        end
        else if (count_reg != '0)
        begin
            shift_next = {shift_reg[DIVIDEND_W-2:0], 1'b0};
            rem_next   = diff[DIVISOR_W] ? trial[DIVISOR_W-1:0] : diff[DIVISOR_W-1:0];
            count_next = count_reg - CNT_W'(1);
            done_next  = (count_reg == CNT_W'(1));
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
            done_reg  <= 1'b0;
        end
        else
        begin
            count_reg <= count_next;
            done_reg  <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        shift_reg   <= shift_next;
        divisor_reg <= divisor_next;
        rem_reg     <= rem_next;
    end

    assign done      = done_reg;
    assign remainder = rem_reg;

endmodule

`default_nettype wire

// ===== sv/rce_seq.sv =====
// Sequencer: key derivation search and repeated multiply/reduce per item.
// Depends on rce_pkg; drives the shared rce_rem_unit.
`default_nettype none

module rce_seq #(
    parameter int PRIME_WIDTH = 8
) (
    input  wire logic                                 clk,
    input  wire logic                                 rst_n,
    input  wire logic                                 start,
    input  wire logic [rce_pkg::CHAR_W-1:0]           plain_char,
    input  wire logic [PRIME_WIDTH-1:0]               prime_p,
    input  wire logic [PRIME_WIDTH-1:0]               prime_q,
    input  wire logic                                 cfg_wr,
    input  wire logic                                 div_done,
    input  wire logic [2*PRIME_WIDTH-1:0]             div_rem,
    output logic                                      div_start,
    output logic [2*PRIME_WIDTH+((PRIME_WIDTH > rce_pkg::CHAR_W) ?
                  PRIME_WIDTH : rce_pkg::CHAR_W)-1:0] div_dividend,
    output logic      [2*PRIME_WIDTH-1:0]             div_divisor,
    output logic                                      busy,
    output logic                                      done,
    output logic signed [rce_pkg::VALUE_W-1:0]        cipher_value,
    output logic      [rce_pkg::CCHAR_W-1:0]          cipher_char
);

    localparam int MW = 2 * PRIME_WIDTH;
    localparam int BW = (PRIME_WIDTH > rce_pkg::CHAR_W) ? PRIME_WIDTH : rce_pkg::CHAR_W;
    localparam int DW = MW + BW;
    localparam int SW = (MW + 1 > rce_pkg::VALUE_W) ? MW + 1 : rce_pkg::VALUE_W;

    rce_pkg::state_t state_reg;
    rce_pkg::state_t state_next;

    logic [MW-1:0]              modulus_reg;
    logic [MW-1:0]              modulus_next;
    logic [MW-1:0]              totient_reg;
    logic [MW-1:0]              totient_next;
    logic [MW-1:0]              exponent_reg;
    logic [MW-1:0]              exponent_next;
    logic                       key_ready_reg;
    logic                       key_ready_next;
    logic [MW-1:0]              cand_reg;
    logic [MW-1:0]              cand_next;
    logic [MW-1:0]              d_reg;
    logic [MW-1:0]              d_next;
    logic [MW:0]                dsq_reg;
    logic [MW:0]                dsq_next;
    logic [MW-1:0]              kmag_reg;
    logic [MW-1:0]              kmag_next;
    logic                       kneg_reg;
    logic                       kneg_next;
    logic [MW-1:0]              rnd_reg;
    logic [MW-1:0]              rnd_next;
    logic [rce_pkg::CHAR_W-1:0] xmag_reg;
    logic [rce_pkg::CHAR_W-1:0] xmag_next;
    logic                       xneg_reg;
    logic                       xneg_next;

    logic [MW-1:0]              mul_a;
    logic [BW-1:0]              mul_b;
    logic [DW-1:0]              mul_p;
    logic [MW-1:0]              p_ext;
    logic [MW-1:0]              q_ext;
    logic [MW-1:0]              rnd_inc;
    logic                       degenerate;
    logic                       cand_exhausted;
    logic                       cand_taken;
    logic                       trial_done;
    logic                       rem_zero;
    logic                       last_round;
    logic                       modulus_zero;
    logic signed [SW-1:0]       kext;
    logic signed [SW-1:0]       kval;

    assign mul_p          = DW'(mul_a) * DW'(mul_b);
    assign p_ext          = MW'(prime_p);
    assign q_ext          = MW'(prime_q);
    assign rnd_inc        = rnd_reg + MW'(1);
    assign degenerate     = (prime_p < PRIME_WIDTH'(2)) || (prime_q < PRIME_WIDTH'(2));
    assign cand_exhausted = cand_reg >= totient_reg;
    assign cand_taken     = (cand_reg == p_ext) || (cand_reg == q_ext);
    assign trial_done     = dsq_reg > {1'b0, cand_reg};
    assign rem_zero       = div_rem == '0;
    assign last_round     = rnd_inc == exponent_reg;
    assign modulus_zero   = modulus_reg == '0;

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            rce_pkg::ST_IDLE:
                if (start)
                    state_next = key_ready_reg ? rce_pkg::ST_ENC_INIT : rce_pkg::ST_KEY_MOD;
            rce_pkg::ST_KEY_MOD:
                state_next = rce_pkg::ST_KEY_TOT;
            rce_pkg::ST_KEY_TOT:
                state_next = rce_pkg::ST_CAND;
            rce_pkg::ST_CAND:
                if (cand_exhausted)
                    state_next = rce_pkg::ST_ENC_INIT;
                else if (!cand_taken)
                    state_next = rce_pkg::ST_TDIV;
            rce_pkg::ST_TDIV:
                if (div_done)
                    state_next = rem_zero ? rce_pkg::ST_CAND : rce_pkg::ST_PRIME;
            rce_pkg::ST_PRIME:
                state_next = trial_done ? rce_pkg::ST_ENC_INIT : rce_pkg::ST_PDIV;
            rce_pkg::ST_PDIV:
                if (div_done)
                    state_next = rem_zero ? rce_pkg::ST_CAND : rce_pkg::ST_PRIME;
            rce_pkg::ST_ENC_INIT:
                state_next = (exponent_reg == '0) ? rce_pkg::ST_OUT : rce_pkg::ST_MUL;
            rce_pkg::ST_MUL:
                if (!modulus_zero)
                    state_next = rce_pkg::ST_MDIV;
                else if (last_round)
                    state_next = rce_pkg::ST_OUT;
            rce_pkg::ST_MDIV:
                if (div_done)
                    state_next = last_round ? rce_pkg::ST_OUT : rce_pkg::ST_MUL;
            rce_pkg::ST_OUT:
                state_next = rce_pkg::ST_IDLE;
            default:
                state_next = rce_pkg::ST_IDLE;
        endcase
    end

    // datapath and divider control
    always_comb
    begin
        modulus_next   = modulus_reg;
        totient_next   = totient_reg;
        exponent_next  = exponent_reg;
        key_ready_next = key_ready_reg;
        cand_next      = cand_reg;
        d_next         = d_reg;
        dsq_next       = dsq_reg;
        kmag_next      = kmag_reg;
        kneg_next      = kneg_reg;
        rnd_next       = rnd_reg;
        xmag_next      = xmag_reg;
        xneg_next      = xneg_reg;
        mul_a          = kmag_reg;
        mul_b          = BW'(xmag_reg);
        div_start      = 1'b0;
        div_dividend   = DW'(totient_reg);
        div_divisor    = cand_reg;
        case (state_reg)
            rce_pkg::ST_IDLE:
                if (start)
                begin
                    xneg_next = plain_char < rce_pkg::CHAR_OFFSET;
                    xmag_next = (plain_char < rce_pkg::CHAR_OFFSET) ?
                                rce_pkg::CHAR_OFFSET - plain_char :
                                plain_char - rce_pkg::CHAR_OFFSET;
                end
            rce_pkg::ST_KEY_MOD:
            begin
                mul_a        = p_ext;
                mul_b        = BW'(prime_q);
                modulus_next = mul_p[MW-1:0];
            end
            rce_pkg::ST_KEY_TOT:
            begin
                mul_a         = p_ext - MW'(1);
                mul_b         = BW'(prime_q) - BW'(1);
                totient_next  = degenerate ? '0 : mul_p[MW-1:0];
                cand_next     = MW'(2);
                exponent_next = '0;
            end
            rce_pkg::ST_CAND:
                if (cand_exhausted)
                begin
                    exponent_next  = '0;
                    key_ready_next = 1'b1;
                end
                else if (cand_taken)
                    cand_next = cand_reg + MW'(1);
                else
                begin
                    div_start    = 1'b1;
                    div_dividend = DW'(totient_reg);
                    div_divisor  = cand_reg;
                end
            rce_pkg::ST_TDIV:
                if (div_done)
                begin
                    if (rem_zero)
                        cand_next = cand_reg + MW'(1);
                    else
                    begin
                        d_next   = MW'(2);
                        dsq_next = (MW + 1)'(4);
                    end
                end
            rce_pkg::ST_PRIME:
                if (trial_done)
                begin
                    exponent_next  = cand_reg;
                    key_ready_next = 1'b1;
                end
                else
                begin
                    div_start    = 1'b1;
                    div_dividend = DW'(cand_reg);
                    div_divisor  = d_reg;
                end
            rce_pkg::ST_PDIV:
                if (div_done)
                begin
                    if (rem_zero)
                        cand_next = cand_reg + MW'(1);
                    else
                    begin
                        d_next   = d_reg + MW'(1);
                        dsq_next = dsq_reg + {d_reg, 1'b1};
                    end
                end
            rce_pkg::ST_ENC_INIT:
            begin
                kmag_next = MW'(1);
                kneg_next = 1'b0;
                rnd_next  = '0;
            end
            rce_pkg::ST_MUL:
            begin
                kneg_next = kneg_reg ^ xneg_reg;
                if (modulus_zero)
                begin
                    kmag_next = mul_p[MW-1:0];
                    rnd_next  = rnd_inc;
                end
                else
                begin
                    div_start    = 1'b1;
                    div_dividend = mul_p;
                    div_divisor  = modulus_reg;
                end
            end
            rce_pkg::ST_MDIV:
                if (div_done)
                begin
                    kmag_next = div_rem;
                    rnd_next  = rnd_inc;
                end
            default: ;
        endcase
        if (cfg_wr)
            key_ready_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= rce_pkg::ST_IDLE;
            modulus_reg   <= '0;
            totient_reg   <= '0;
            exponent_reg  <= '0;
            key_ready_reg <= 1'b0;
            rnd_reg       <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            modulus_reg   <= modulus_next;
            totient_reg   <= totient_next;
            exponent_reg  <= exponent_next;
            key_ready_reg <= key_ready_next;
            rnd_reg       <= rnd_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cand_reg <= cand_next;
        d_reg    <= d_next;
        dsq_reg  <= dsq_next;
        kmag_reg <= kmag_next;
        kneg_reg <= kneg_next;
        xmag_reg <= xmag_next;
        xneg_reg <= xneg_next;
    end

    assign kext         = signed'(SW'(kmag_reg));
    assign kval         = kneg_reg ? -kext : kext;
    assign busy         = state_reg != rce_pkg::ST_IDLE;
    assign done         = state_reg == rce_pkg::ST_OUT;
    assign cipher_value = kval[rce_pkg::VALUE_W-1:0];
    assign cipher_char  = kval[rce_pkg::CCHAR_W-1:0] + rce_pkg::CCHAR_OFFSET;

endmodule

`default_nettype wire

// ===== sv/rsa_char_encrypt_core.sv =====
// Top level of the character RSA encryption core.
// Depends on rce_pkg, rce_cfg_regs, rce_rem_unit, rce_seq.
//
// channel   | handshake                 | payload
// ----------+---------------------------+------------------------------
// config    | psel/penable/pwrite/pready | paddr, pwdata, prdata
// item in   | start, busy               | plain_char
// item out  | done (1-cycle strobe)     | cipher_value, cipher_char
//
// An item runs E multiply/reduce rounds, E the exponent; each product of D = 2*PRIME_WIDTH +
// max(PRIME_WIDTH,7) bits (24 at default) goes through the serial remainder unit, one bit a cycle,
// unless the modulus is zero. The first item after reset or a prime write also runs the key
// search, with remainders on the same unit for each candidate tried.
// Async active-low reset; busy is high from accept through the done cycle.
// Results cannot be stalled; done is high for one cycle only.
`default_nettype none

module rsa_char_encrypt_core #(
    parameter int PRIME_WIDTH = 8
) (
    input  wire logic                                  clk,
    input  wire logic                                  rst_n,
    input  wire logic                                  psel,
    input  wire logic                                  penable,
    input  wire logic                                  pwrite,
    input  wire logic        [rce_pkg::ADDR_W-1:0]     paddr,
    input  wire logic        [rce_pkg::DATA_W-1:0]     pwdata,
    output logic             [rce_pkg::DATA_W-1:0]     prdata,
    output logic                                       pready,
    input  wire logic                                  start,
    input  wire logic        [rce_pkg::CHAR_W-1:0]     plain_char,
    output logic                                       busy,
    output logic                                       done,
    output logic signed      [rce_pkg::VALUE_W-1:0]    cipher_value,
    output logic             [rce_pkg::CCHAR_W-1:0]    cipher_char
);

    localparam int MW = 2 * PRIME_WIDTH;
    localparam int BW = (PRIME_WIDTH > rce_pkg::CHAR_W) ? PRIME_WIDTH : rce_pkg::CHAR_W;
    localparam int DW = MW + BW;

    logic [PRIME_WIDTH-1:0] prime_p;
    logic [PRIME_WIDTH-1:0] prime_q;
    logic                   cfg_wr;
    logic                   div_start;
    logic [DW-1:0]          div_dividend;
    logic [MW-1:0]          div_divisor;
    logic                   div_done;
    logic [MW-1:0]          div_rem;

    rce_cfg_regs #(
        .PRIME_WIDTH (PRIME_WIDTH)
    ) u_cfg (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .prime_p (prime_p),
        .prime_q (prime_q),
        .cfg_wr  (cfg_wr)
    );

    rce_rem_unit #(
        .DIVIDEND_W (DW),
        .DIVISOR_W  (MW)
    ) u_rem (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (div_start),
        .dividend  (div_dividend),
        .divisor   (div_divisor),
        .done      (div_done),
        .remainder (div_rem)
    );

    rce_seq #(
        .PRIME_WIDTH (PRIME_WIDTH)
    ) u_seq (
        .clk          (clk),
        .rst_n        (rst_n),
        .start        (start),
        .plain_char   (plain_char),
        .prime_p      (prime_p),
        .prime_q      (prime_q),
        .cfg_wr       (cfg_wr),
        .div_done     (div_done),
        .div_rem      (div_rem),
        .div_start    (div_start),
        .div_dividend (div_dividend),
        .div_divisor  (div_divisor),
        .busy         (busy),
        .done         (done),
        .cipher_value (cipher_value),
        .cipher_char  (cipher_char)
    );

endmodule

`default_nettype wire

// ===== sv/rce_chk.sv =====
// Port-level checker for rsa_char_encrypt_core, attached by bind.
// Depends on rce_pkg and rsa_char_encrypt_core_assert.svh.
`default_nettype none

`include "rsa_char_encrypt_core_assert.svh"

module rce_chk (
    input wire logic                               clk,
    input wire logic                               rst_n,
    input wire logic                               start,
    input wire logic                               busy,
    input wire logic                               done,
    input wire logic signed [rce_pkg::VALUE_W-1:0] cipher_value,
    input wire logic        [rce_pkg::CCHAR_W-1:0] cipher_char
);

    logic [rce_pkg::CCHAR_W-1:0] char_expected;

    assign char_expected = cipher_value[rce_pkg::CCHAR_W-1:0] + rce_pkg::CCHAR_OFFSET;

    `RCE_ASSERT_IMP(a_done_while_busy, clk, rst_n, done, busy)
    `RCE_ASSERT_NXT(a_accept_sets_busy, clk, rst_n, start && !busy, busy)
    `RCE_ASSERT_NXT(a_done_then_idle, clk, rst_n, done, !done && !busy)
    `RCE_ASSERT_IMP(a_char_matches, clk, rst_n, done, cipher_char == char_expected)

endmodule

bind rsa_char_encrypt_core rce_chk u_rce_chk (
    .clk          (clk),
    .rst_n        (rst_n),
    .start        (start),
    .busy         (busy),
    .done         (done),
    .cipher_value (cipher_value),
    .cipher_char  (cipher_char)
);

`default_nettype wire

// ===== dv/rsa_char_encrypt_core_checker.sv =====
`timescale 1ns / 100ps
// Scoreboard for rsa_char_encrypt_core: follows prime writes, predicts each cipher item
// and compares every done strobe against the oldest prediction. Depends on rce_pkg.

module rsa_char_encrypt_core_checker
    import rce_pkg::*;
(
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       psel,
    input  logic                       penable,
    input  logic                       pwrite,
    input  logic                       pready,
    input  logic [ADDR_W-1:0]          paddr,
    input  logic [DATA_W-1:0]          pwdata,
    input  logic                       start,
    input  logic                       busy,
    input  logic [CHAR_W-1:0]          plain_char,
    input  logic                       done,
    input  logic signed [VALUE_W-1:0]  cipher_value,
    input  logic [CCHAR_W-1:0]         cipher_char,
    output int                         errors,
    output int                         pending,
    output int                         results
);

    localparam int PRIME_W = 8;
    localparam int SHOWN_MISMATCHES = 10;

    typedef struct
    {
        logic [CHAR_W-1:0]          plain;
        logic signed [VALUE_W-1:0]  value;
        logic [CCHAR_W-1:0]         cchar;
    } cipher_item_t;

    cipher_item_t        expected_ciphers[$];
    logic [PRIME_W-1:0]  prime_p;
    logic [PRIME_W-1:0]  prime_q;
    longint              modulus;
    longint              totient;
    longint              exponent;
    bit                  key_ready;

    // smallest prime below t that does not divide t and is neither factor; 0 if none
    function automatic longint public_exponent(longint p, longint q, longint t);
        longint cand;
        longint d;
        bit     is_prime;
        for (cand = 2; cand < t; cand++)
        begin
            if (t % cand == 0)
                continue;
            is_prime = 1'b1;
            for (d = 2; d * d <= cand; d++)
                if (cand % d == 0)
                    is_prime = 1'b0;
            if (is_prime && cand != p && cand != q)
                return cand;
        end
        return 0;
    endfunction

    function automatic cipher_item_t encrypt_char(logic [CHAR_W-1:0] c, longint n, longint e);
        cipher_item_t item;
        longint       x;
        longint       k;
        longint       r;
        x = longint'(c) - longint'(CHAR_OFFSET);
        k = 1;
        for (r = 0; r < e; r++)
        begin
            k = k * x;
            if (n != 0)
                k = k % n;  // truncating remainder, sign follows k
        end
        item.plain = c;
        item.value = k[VALUE_W-1:0];
        item.cchar = k[CCHAR_W-1:0] + CCHAR_OFFSET;
        return item;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin : scoreboard
        cipher_item_t want;
        if (!rst_n)
        begin
            expected_ciphers.delete();
            prime_p   = PRIME_W'(RESET_P);
            prime_q   = PRIME_W'(RESET_Q);
            modulus   = 0;
            totient   = 0;
            exponent  = 0;
            key_ready = 1'b0;
        end
        else
        begin
            if (psel && penable && pwrite && pready)
            begin
                case (reg_idx_t'(paddr[2]))
                    REG_PRIME_P: prime_p = pwdata[PRIME_W-1:0];
                    REG_PRIME_Q: prime_q = pwdata[PRIME_W-1:0];
                    default: ;
                endcase
                key_ready = 1'b0;
            end
            if (done)
            begin
                results++;
                if (expected_ciphers.size() == 0)
                begin
                    errors++;
                    if (errors <= SHOWN_MISMATCHES)
                        $display("unexpected cipher item: value %0d char 0x%02h",
                                 cipher_value, cipher_char);
                end
                else
                begin
                    want = expected_ciphers.pop_front();
                    if (cipher_value !== want.value || cipher_char !== want.cchar)
                    begin
                        errors++;
                        if (errors <= SHOWN_MISMATCHES)
                        begin
                            $display("cipher mismatch for char %0d (p=%0d q=%0d):",
                                     want.plain, prime_p, prime_q);
                            $display("  expected value %0d char 0x%02h, got value %0d char 0x%02h",
                                     want.value, want.cchar, cipher_value, cipher_char);
                        end
                    end
                end
            end
            if (start && !busy)
            begin
                if (!key_ready)
                begin
                    modulus   = longint'(prime_p) * longint'(prime_q);
                    totient   = (longint'(prime_p) - 1) * (longint'(prime_q) - 1);
                    exponent  = public_exponent(longint'(prime_p), longint'(prime_q), totient);
                    key_ready = 1'b1;
                end
                expected_ciphers.push_back(encrypt_char(plain_char, modulus, exponent));
            end
        end
        pending = expected_ciphers.size();
    end

endmodule

// ===== dv/rsa_char_encrypt_core_test.sv =====
`timescale 1ns / 100ps
// Top of the rsa_char_encrypt_core testbench: clock, reset, prime writes and characters.
// Depends on rce_pkg, the core and rsa_char_encrypt_core_checker.

module rsa_char_encrypt_core_test;
    import rce_pkg::*;

    localparam int RANDOM_ITEMS   = 1800;
    localparam int CALM_ITEMS     = 300;
    localparam int WATCHDOG_LIMIT = 100000;
    localparam int TAIL_CYCLES    = 50;

    logic                       clk;
    logic                       rst_n;
    logic                       psel;
    logic                       penable;
    logic                       pwrite;
    logic [ADDR_W-1:0]          paddr;
    logic [DATA_W-1:0]          pwdata;
    logic [DATA_W-1:0]          prdata;
    logic                       pready;
    logic                       start;
    logic [CHAR_W-1:0]          plain_char;
    logic                       busy;
    logic                       done;
    logic signed [VALUE_W-1:0]  cipher_value;
    logic [CCHAR_W-1:0]         cipher_char;

    int  check_errors;
    int  check_pending;
    int  check_results;
    int  chars_sent;
    int  key_settings;
    int  idle_cycles;
    bit  calm;

    byte unsigned primes [54] = '{
        2, 3, 5, 7, 11, 13, 17, 19, 23, 29, 31, 37, 41, 43, 47, 53, 59, 61, 67, 71,
        73, 79, 83, 89, 97, 101, 103, 107, 109, 113, 127, 131, 137, 139, 149, 151,
        157, 163, 167, 173, 179, 181, 191, 193, 197, 199, 211, 223, 227, 229, 233,
        239, 241, 251
    };

    rsa_char_encrypt_core #(
        .PRIME_WIDTH (8)
    ) dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .psel         (psel),
        .penable      (penable),
        .pwrite       (pwrite),
        .paddr        (paddr),
        .pwdata       (pwdata),
        .prdata       (prdata),
        .pready       (pready),
        .start        (start),
        .plain_char   (plain_char),
        .busy         (busy),
        .done         (done),
        .cipher_value (cipher_value),
        .cipher_char  (cipher_char)
    );

    rsa_char_encrypt_core_checker cipher_check (
        .clk          (clk),
        .rst_n        (rst_n),
        .psel         (psel),
        .penable      (penable),
        .pwrite       (pwrite),
        .pready       (pready),
        .paddr        (paddr),
        .pwdata       (pwdata),
        .start        (start),
        .busy         (busy),
        .plain_char   (plain_char),
        .done         (done),
        .cipher_value (cipher_value),
        .cipher_char  (cipher_char),
        .errors       (check_errors),
        .pending      (check_pending),
        .results      (check_results)
    );

    always
    begin
        clk = 1'b0;
        #5;
        clk = 1'b1;
        #5;
    end

    always @(posedge clk)
    begin
        if (!rst_n || (start && !busy) || done || (psel && penable && pwrite && pready))
            idle_cycles <= 0;
        else if (idle_cycles >= WATCHDOG_LIMIT)
        begin
            $display("watchdog: no item moved for %0d cycles", idle_cycles);
            $display("Some tests failed");
            $finish;
        end
        else
            idle_cycles <= idle_cycles + 1;
    end

    // all tasks enter and leave on a falling edge
    task automatic wait_idle();
        start = 1'b0;
        while (check_pending != 0 || busy)
            @(negedge clk);
    endtask

    task automatic write_prime(input reg_idx_t idx, input logic [7:0] val);
        psel    = 1'b1;
        penable = 1'b0;
        pwrite  = 1'b1;
        paddr   = {idx, 2'b00};
        pwdata  = {24'($urandom()), val};
        @(negedge clk);
        penable = 1'b1;
        do
            @(posedge clk);
        while (!pready);
        @(negedge clk);
        psel    = 1'b0;
        penable = 1'b0;
        pwrite  = 1'b0;
    endtask

    task automatic set_key(input logic [7:0] p, input logic [7:0] q);
        wait_idle();
        write_prime(REG_PRIME_P, p);
        write_prime(REG_PRIME_Q, q);
        key_settings++;
    endtask

    task automatic encrypt(input logic [CHAR_W-1:0] c);
        int gap;
        bit taken;
        gap = (!calm && $urandom_range(0, 3) == 0) ? $urandom_range(1, 13) : 0;
        if (gap > 0)
        begin
            start = 1'b0;
            repeat (gap) @(negedge clk);
        end
        start      = 1'b1;
        plain_char = c;
        taken      = 1'b0;
        while (!taken)
        begin
            @(posedge clk);
            taken = !busy;
            @(negedge clk);
        end
        chars_sent++;
    endtask

    initial
    begin
        int                 n_random;
        int                 phase_len;
        logic [7:0]         p;
        logic [7:0]         q;
        logic [CHAR_W-1:0]  c;

        rst_n      = 1'b0;
        psel       = 1'b0;
        penable    = 1'b0;
        pwrite     = 1'b0;
        paddr      = '0;
        pwdata     = '0;
        start      = 1'b0;
        plain_char = '0;
        calm       = 1'b0;
        repeat (2) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // reset key 2*3: totient too small, exponent 0
        encrypt(7'd0);
        encrypt(7'd127);
        encrypt(7'd96);

        // largest prime pair
        set_key(8'd251, 8'd241);
        encrypt(7'd0);
        encrypt(7'd1);
        encrypt(7'd127);
        encrypt(7'd95);
        encrypt(7'd97);

        // equal, non-prime factors at the top of the range
        set_key(8'd255, 8'd255);
        encrypt(7'd127);
        encrypt(7'd0);
        encrypt(7'd96);

        // zero modulus
        set_key(8'd0, 8'd7);
        encrypt(7'd65);
        encrypt(7'd127);

        // modulus one with exponent 0
        set_key(8'd1, 8'd1);
        encrypt(7'd33);

        // small candidates skipped because they equal a factor
        set_key(8'd3, 8'd5);
        encrypt(7'd1);
        encrypt(7'd127);
        encrypt(7'd120);

        wait_idle();
        write_prime(REG_PRIME_Q, 8'd255);
        key_settings++;
        encrypt(7'd64);
        encrypt(7'd2);

        n_random = 0;
        while (n_random < RANDOM_ITEMS)
        begin
            p = ($urandom_range(0, 19) < 17) ? 8'(primes[$urandom_range(0, 53)])
                                             : 8'($urandom_range(0, 255));
            q = ($urandom_range(0, 19) < 17) ? 8'(primes[$urandom_range(0, 53)])
                                             : 8'($urandom_range(0, 255));
            if ($urandom_range(0, 5) == 0)
            begin
                wait_idle();
                write_prime(($urandom_range(0, 1) == 0) ? REG_PRIME_P : REG_PRIME_Q, p);
                key_settings++;
            end
            else
                set_key(p, q);
            calm      = ($urandom_range(0, 3) == 0);
            phase_len = $urandom_range(10, 100);
            for (int i = 0; i < phase_len && n_random < RANDOM_ITEMS; i++)
            begin
                if (n_random >= RANDOM_ITEMS - CALM_ITEMS)
                    calm = 1'b1;
                case ($urandom_range(0, 9))
                    0:       c = 7'd0;
                    1:       c = 7'd127;
                    2:       c = 7'd95;
                    3:       c = 7'd96;
                    4:       c = 7'd97;
                    default: c = 7'($urandom_range(0, 127));
                endcase
                encrypt(c);
                n_random++;
            end
        end

        wait_idle();
        repeat (TAIL_CYCLES) @(posedge clk);

        $display("Encrypted %0d characters under %0d key settings; %0d cipher items checked.",
                 chars_sent, key_settings, check_results);
        $display("Keys spanned zero and unit factors, equal and non-prime factors, and 251*241.");
        if (check_errors == 0 && check_pending == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

endmodule
